// ----- sv/lsse_pkg.sv -----
// ----------------------------------------------------------------------------
// LED strip slot encoder package
// Shared constants, command and status codes and state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package lsse_pkg;

  localparam int unsigned MaxLedsDefault = 64;
  localparam int unsigned BitsPerLed     = 24;
  localparam int unsigned ColorW         = 24;
  localparam int unsigned CfgAddrW       = 4;
  localparam logic [4:0]  LedMsb         = 5'd23;
  localparam logic [6:0]  LedCountReset  = 7'd1;
  localparam logic [7:0]  ResetSlotsInit = 8'd50;

  typedef enum logic [1:0] {
    CMD_SET_ONE   = 2'd0,
    CMD_SET_ALL   = 2'd1,
    CMD_SET_RANGE = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_PENDING   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_LED_COUNT   = 2'd0,
    REG_HIGH_DUTY   = 2'd1,
    REG_LOW_DUTY    = 2'd2,
    REG_RESET_SLOTS = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_TICK
  } state_e;

endpackage

`default_nettype wire

// ----- sv/lsse_store.sv -----
// ----------------------------------------------------------------------------
// LED strip colour store
// One write port and one registered read port, with a valid bit per entry so
// that entries not yet written read as black after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lsse_store #(
  parameter int unsigned Depth = lsse_pkg::MaxLedsDefault,
  parameter int unsigned AW    = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [lsse_pkg::ColorW-1:0]  wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [lsse_pkg::ColorW-1:0]  rdata_o
);
  import lsse_pkg::*;

  logic [ColorW-1:0] mem_q [Depth];
  logic [Depth-1:0]  valid_q;
  logic [ColorW-1:0] rd_data_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_data_q <= mem_q[raddr_i];
    rd_vld_q  <= valid_q[raddr_i];
  end

  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ----- sv/led_strip_slot_encoder.sv -----
// ----------------------------------------------------------------------------
// LED strip slot encoder
// Holds one colour per LED and streams the strip as PWM duty slots.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Write requests set
// one LED, all LEDs or an inclusive range; slot ticks return one duty value.
// Every request yields exactly one result, shown for one cycle with done_o.
// A tick or a write with nothing to store answers in the cycle after accept.
// A tick while sending answers through ST_TICK: one colour store read, then the
// bit select. A write walks the store one entry per cycle, writing at most
// MAX_LEDS entries, and answers once the last entry is written.
// Slots go out green, red, blue, MSB first, then reset_slots zero slots.
// Registers sit on an APB-style port at byte addresses 0, 4, 8 and 12. They
// are to be written only while the block is idle; the block does not enforce it.
// Reset clears the store and the frame state and sets the registers to their
// reset values at once; no clearing pass is needed. The receiver cannot stall:
// a result is presented for exactly one cycle and must be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_slot_encoder #(
  parameter int unsigned MAX_LEDS = lsse_pkg::MaxLedsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsse_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [5:0]                    led_index_i,
  input  logic [5:0]                    range_last_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    blue_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic                          slot_valid_o,
  output logic [15:0]                   duty_o,
  output logic                          frame_end_o,
  output logic                          active_o
);
  import lsse_pkg::*;

  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned NW = $clog2(MAX_LEDS + 1);
  localparam int unsigned PW = $clog2(BitsPerLed * MAX_LEDS + 256);
  localparam int unsigned LW = $clog2(MAX_LEDS + 12);

  logic [6:0]  led_count_q;
  logic [15:0] high_duty_q;
  logic [15:0] low_duty_q;
  logic [7:0]  reset_slots_q;
  logic        cfg_wr;

  state_e      state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [LW-1:0] led_q, led_d;
  logic [4:0]  bit_q, bit_d;
  logic        sending_q, sending_d;
  logic        pending_q, pending_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] last_q, last_d;
  logic [ColorW-1:0] color_q, color_d;

  logic        done_q, done_d;
  logic [1:0]  res_status_q, res_status_d;
  logic        res_valid_q, res_valid_d;
  logic [15:0] res_duty_q, res_duty_d;
  logic        res_fend_q, res_fend_d;
  logic        res_active_q, res_active_d;

  logic [NW-1:0] n_eff;
  logic [PW-1:0] bits_w;
  logic [PW-1:0] total_w;
  logic [PW-1:0] pos_inc;
  logic          in_bits;
  logic          frame_done;
  logic          first_ok;
  logic          last_ok;
  logic          ok;
  logic [ColorW-1:0] rd_word;
  logic          mem_we;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q   <= LedCountReset;
      high_duty_q   <= '0;
      low_duty_q    <= '0;
      reset_slots_q <= ResetSlotsInit;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[3:2]))
        REG_LED_COUNT:   led_count_q   <= pwdata[6:0];
        REG_HIGH_DUTY:   high_duty_q   <= pwdata[15:0];
        REG_LOW_DUTY:    low_duty_q    <= pwdata[15:0];
        REG_RESET_SLOTS: reset_slots_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_LED_COUNT:   prdata = {25'd0, led_count_q};
      REG_HIGH_DUTY:   prdata = {16'd0, high_duty_q};
      REG_LOW_DUTY:    prdata = {16'd0, low_duty_q};
      REG_RESET_SLOTS: prdata = {24'd0, reset_slots_q};
      default:         prdata = '0;
    endcase
  end

  assign n_eff = (32'(led_count_q) < MAX_LEDS) ? NW'(led_count_q) : NW'(MAX_LEDS);
  assign bits_w  = (PW'(n_eff) << 4) + (PW'(n_eff) << 3);
  assign total_w = bits_w + PW'(reset_slots_q);
  assign pos_inc = pos_q + PW'(1);
  assign in_bits = pos_q < bits_w;
  assign frame_done = (total_w == '0) || (pos_inc >= total_w);
  assign first_ok = 32'(led_index_i) < 32'(n_eff);
  assign last_ok  = 32'(range_last_i) < 32'(n_eff);

  lsse_store #(
    .Depth (MAX_LEDS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (cur_q),
    .wdata_i (color_q),
    .raddr_i (led_q[AW-1:0]),
    .rdata_o (rd_word)
  );

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    led_d        = led_q;
    bit_d        = bit_q;
    sending_d    = sending_q;
    pending_d    = pending_q;
    cur_d        = cur_q;
    last_d       = last_q;
    color_d      = color_q;
    done_d       = 1'b0;
    res_status_d = res_status_q;
    res_valid_d  = res_valid_q;
    res_duty_d   = res_duty_q;
    res_fend_d   = res_fend_q;
    res_active_d = res_active_q;
    mem_we       = 1'b0;
    ok           = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          color_d      = {green_i, red_i, blue_i};
          res_valid_d  = 1'b0;
          res_duty_d   = '0;
          res_fend_d   = 1'b0;
          res_status_d = STATUS_OK;
          if (cmd_e'(cmd_i) == CMD_TICK) begin
            if (sending_q) begin
              state_d = ST_TICK;
            end else begin
              done_d       = 1'b1;
              res_active_d = 1'b0;
            end
          end else begin
            case (cmd_e'(cmd_i))
              CMD_SET_ONE: begin
                ok     = first_ok;
                cur_d  = AW'(led_index_i);
                last_d = AW'(led_index_i);
                if (ok) begin
                  state_d = ST_WALK;
                end
              end
              CMD_SET_ALL: begin
                cur_d  = '0;
                last_d = AW'(n_eff - NW'(1));
                if (n_eff != '0) begin
                  state_d = ST_WALK;
                end
              end
              default: begin
                ok     = first_ok && last_ok;
                cur_d  = AW'(led_index_i);
                last_d = AW'(range_last_i);
                if (ok && (led_index_i <= range_last_i)) begin
                  state_d = ST_WALK;
                end
              end
            endcase
            if (!ok) begin
              res_status_d = STATUS_BAD_INDEX;
            end else if (pending_q) begin
              res_status_d = STATUS_PENDING;
            end else begin
              pending_d = 1'b1;
              if (!sending_q) begin
                sending_d = 1'b1;
                pos_d     = '0;
                led_d     = '0;
                bit_d     = '0;
              end
            end
            res_active_d = sending_d;
            if (state_d == ST_IDLE) begin
              done_d = 1'b1;
            end
          end
        end
      end
      ST_WALK: begin
        mem_we = 1'b1;
        if (cur_q == last_q) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end
      ST_TICK: begin
        state_d     = ST_IDLE;
        done_d      = 1'b1;
        res_valid_d = 1'b1;
        res_fend_d  = frame_done;
        if (in_bits) begin
          res_duty_d = rd_word[LedMsb - bit_q] ? high_duty_q : low_duty_q;
        end
        if (frame_done) begin
          pos_d = '0;
          led_d = '0;
          bit_d = '0;
          if (pending_q) begin
            pending_d = 1'b0;
          end else begin
            sending_d = 1'b0;
          end
        end else begin
          pos_d = pos_inc;
          if (bit_q == LedMsb) begin
            bit_d = '0;
            led_d = led_q + LW'(1);
          end else begin
            bit_d = bit_q + 5'd1;
          end
        end
        res_active_d = sending_d;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      led_q     <= '0;
      bit_q     <= '0;
      sending_q <= 1'b0;
      pending_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      led_q     <= led_d;
      bit_q     <= bit_d;
      sending_q <= sending_d;
      pending_q <= pending_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    last_q       <= last_d;
    color_q      <= color_d;
    res_status_q <= res_status_d;
    res_valid_q  <= res_valid_d;
    res_duty_q   <= res_duty_d;
    res_fend_q   <= res_fend_d;
    res_active_q <= res_active_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = res_status_q;
  assign slot_valid_o = res_valid_q;
  assign duty_o       = res_duty_q;
  assign frame_end_o  = res_fend_q;
  assign active_o     = res_active_q;

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result presented while a request is still in progress.");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("Accepted request neither in progress nor answered.");

  a_frame_end_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && frame_end_o) |-> (slot_valid_o && (status_o == STATUS_OK)))
    else $error("Frame end reported without a valid slot.");

  a_idle_tick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !slot_valid_o && (status_o == STATUS_OK)) |-> (duty_o == '0))
    else $error("Non-zero duty reported without a valid slot.");

endmodule

`default_nettype wire
